// File: rtl/rcdm_pkg.sv
`default_nettype none

package rcdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NORM_W     = 17;
  localparam int CMD_W      = 25;
  localparam int STEP_W     = 31;
  localparam int NUM_MOTORS = 6;
  localparam int NUM_RATES  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACTION_LIMIT,
    REG_FRONT_LIMIT,
    REG_REAR_LIMIT,
    REG_TRACTION_SLEW,
    REG_FRONT_SLEW,
    REG_REAR_SLEW,
    REG_STALE_LIMIT,
    REG_INVERT_MASK
  } cfg_reg_t;

  localparam logic [11:0] PULSE_MIN = 12'd1000;
  localparam logic [11:0] PULSE_MAX = 12'd2000;
  localparam logic [11:0] DEAD_LOW  = 12'd1480;
  localparam logic [11:0] DEAD_HIGH = 12'd1520;
  localparam logic [11:0] SIDE_LOW  = 12'd1450;
  localparam logic [11:0] SIDE_HIGH = 12'd1550;

  // x * 1024 / 15 == (x * RECIP_15) >> 13 for x <= 480
  localparam logic [19:0] RECIP_15     = 20'd559241;
  // a / 125 == (a * RECIP_125_HI) >> 23 for 16-bit a
  localparam logic [16:0] RECIP_125_HI = 17'd67109;
  // z / 125 == (z * RECIP_125_LO) >> 35 for 28-bit z
  localparam logic [28:0] RECIP_125_LO = 29'd274877907;
  localparam logic [6:0]  DIV_125      = 7'd125;

  localparam logic [16:0] CENTER_MAX    = 17'd1638;
  localparam logic [32:0] SNAP_TRACTION = 33'd5120;
  localparam logic [32:0] SNAP_REAR     = 33'd2560;
  localparam logic signed [17:0] ONE_Q  = 18'sd32768;

  typedef logic signed [CMD_W-1:0] cmd_t;

endpackage

`default_nettype wire

// File: rtl/rc_drive_mixer_ramp.sv
// Radio drive mixer with ramped motor commands.
// Configuration: cfg_we writes cfg_data into register cfg_index;
//   write only while the block is idle (no transfer in flight).
// Input channel: in_valid/in_stall carry one control tick (five pulse widths,
//   frame age, frame-seen flag, elapsed ms). A transfer happens when in_valid
//   is high and in_stall is low.
// Output channel: out_valid/out_stall carry six RPM commands plus the armed
//   and failsafe flags, one result per tick, in tick order.
// Throughput: one tick per cycle while out_stall does not hold a result; the
//   five-stage pipeline (input register, normalize, scale, step divide,
//   ramp/result register) advances as a whole.
// The ramp stage holds the six motor commands and the armed flag; each tick
//   updates them as it enters the result register.
// Stall: while out_stall holds a valid result, the whole pipeline freezes and
//   in_stall is raised; the result register frees up the same cycle it is
//   taken, so no bubble is inserted.
// Reset: clears all valids, motor commands and the armed flag, and restores
//   the register defaults.
`default_nettype none

module rc_drive_mixer_ramp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rcdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rcdm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [11:0]                      throttle_pw,
  input  wire logic [11:0]                      steering_pw,
  input  wire logic [11:0]                      flipper_move_us,
  input  wire logic [11:0]                      flipper_side_us,
  input  wire logic [11:0]                      flipper_pair_us,
  input  wire logic [15:0]                      frame_age_ms,
  input  wire logic                             frame_seen,
  input  wire logic [15:0]                      elapsed_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [15:0]                    left_rpm,
  output logic signed [15:0]                    right_rpm,
  output logic signed [15:0]                    front_left_rpm,
  output logic signed [15:0]                    front_right_rpm,
  output logic signed [15:0]                    rear_left_rpm,
  output logic signed [15:0]                    rear_right_rpm,
  output logic                                  armed,
  output logic                                  failsafe
);
  import rcdm_pkg::*;

  function automatic logic signed [NORM_W-1:0] norm_pulse(input logic [11:0] raw);
    logic [11:0] p;
    logic [8:0]  d;
    logic [28:0] prod;
    logic [16:0] mag;
    logic signed [NORM_W-1:0] res;
    p = raw;
    if (raw < PULSE_MIN) p = PULSE_MIN;
    if (raw > PULSE_MAX) p = PULSE_MAX;
    res = '0;
    if (p > DEAD_HIGH) begin
      d    = 9'(p - DEAD_HIGH);
      prod = 29'(d) * 29'(RECIP_15);
      mag  = 17'(prod >> 13);
      res  = signed'(mag);
    end else if (p < DEAD_LOW) begin
      d    = 9'(DEAD_LOW - p);
      prod = 29'(d) * 29'(RECIP_15);
      mag  = 17'(prod >> 13);
      res  = -signed'(mag);
    end
    return res;
  endfunction

  function automatic logic is_centred(input logic signed [NORM_W-1:0] v);
    logic [NORM_W-1:0] a;
    a = (v < 0) ? NORM_W'(-v) : NORM_W'(v);
    return a <= CENTER_MAX;
  endfunction

  function automatic logic signed [17:0] sat_one(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v > ONE_Q) r = ONE_Q;
    if (v < -ONE_Q) r = -ONE_Q;
    return r;
  endfunction

  function automatic cmd_t scale(input logic signed [17:0] v, input logic [14:0] lim);
    logic signed [33:0] ve;
    logic signed [33:0] le;
    logic signed [33:0] prod;
    ve   = 34'(v);
    le   = signed'(34'(lim));
    prod = ve * le;
    if (prod < 0) prod = prod + 34'sd127;
    return CMD_W'(prod >>> 7);
  endfunction

  // configuration
  logic [14:0] traction_rpm_limit, front_flipper_rpm_limit, rear_flipper_rpm_limit;
  logic [15:0] slew_rate [NUM_RATES];
  logic [15:0] stale_limit_ms;
  logic [5:0]  invert_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      traction_rpm_limit      <= 15'd14000;
      front_flipper_rpm_limit <= 15'd10500;
      rear_flipper_rpm_limit  <= 15'd1500;
      slew_rate[0]            <= 16'd6000;
      slew_rate[1]            <= 16'd2000;
      slew_rate[2]            <= 16'd1000;
      stale_limit_ms          <= 16'd300;
      invert_mask             <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRACTION_LIMIT: traction_rpm_limit      <= cfg_data[14:0];
        REG_FRONT_LIMIT:    front_flipper_rpm_limit <= cfg_data[14:0];
        REG_REAR_LIMIT:     rear_flipper_rpm_limit  <= cfg_data[14:0];
        REG_TRACTION_SLEW:  slew_rate[0]            <= cfg_data;
        REG_FRONT_SLEW:     slew_rate[1]            <= cfg_data;
        REG_REAR_SLEW:      slew_rate[2]            <= cfg_data;
        REG_STALE_LIMIT:    stale_limit_ms          <= cfg_data;
        REG_INVERT_MASK:    invert_mask             <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic        v1;
  logic [11:0] thr1, str1, mov1, side1, pair1;
  logic [15:0] age1, el1;
  logic        seen1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      thr1  <= throttle_pw;
      str1  <= steering_pw;
      mov1  <= flipper_move_us;
      side1 <= flipper_side_us;
      pair1 <= flipper_pair_us;
      age1  <= frame_age_ms;
      seen1 <= frame_seen;
      el1   <= elapsed_ms;
    end
  end

  // stage 2: normalize sticks, rate times elapsed
  logic                     v2, fs2;
  logic signed [NORM_W-1:0] thr2, str2, mov2;
  logic                     both2, left2, right2, front2, rear2;
  logic [31:0]              prod2 [NUM_RATES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fs2    <= (age1 > stale_limit_ms) || !seen1;
      thr2   <= norm_pulse(thr1);
      str2   <= -norm_pulse(str1);
      mov2   <= norm_pulse(mov1);
      both2  <= (side1 >= SIDE_LOW) && (side1 <= SIDE_HIGH);
      left2  <= side1 < SIDE_LOW;
      right2 <= side1 > SIDE_HIGH;
      front2 <= pair1 < SIDE_LOW;
      rear2  <= pair1 > SIDE_HIGH;
      for (int r = 0; r < NUM_RATES; r++) begin
        prod2[r] <= 32'(slew_rate[r]) * 32'(el1);
      end
    end
  end

  // stage 3: mix, scale, route, invert; first half of the divide by 125
  logic        v3, fs3, cen3;
  cmd_t        tgt3 [NUM_MOTORS];
  logic [9:0]  qa3 [NUM_RATES];
  logic [6:0]  ra3 [NUM_RATES];
  logic [15:0] lo3 [NUM_RATES];

  cmd_t        tgt3_next [NUM_MOTORS];
  logic [9:0]  qa3_next [NUM_RATES];
  logic [6:0]  ra3_next [NUM_RATES];

  always_comb begin
    cmd_t        tl, tr, fb, rb;
    logic [32:0] qprod;
    logic [16:0] qmul;
    tl = scale(sat_one(18'(thr2) + 18'(str2)), traction_rpm_limit);
    tr = scale(sat_one(18'(thr2) - 18'(str2)), traction_rpm_limit);
    fb = scale(18'(mov2), front_flipper_rpm_limit);
    rb = scale(18'(mov2), rear_flipper_rpm_limit);
    tgt3_next[0] = tl;
    tgt3_next[1] = tr;
    tgt3_next[2] = (front2 && (both2 || left2))  ? fb : '0;
    tgt3_next[3] = (front2 && (both2 || right2)) ? fb : '0;
    tgt3_next[4] = (rear2 && (both2 || left2))   ? rb : '0;
    tgt3_next[5] = (rear2 && (both2 || right2))  ? rb : '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (invert_mask[i]) tgt3_next[i] = -tgt3_next[i];
    end
    for (int r = 0; r < NUM_RATES; r++) begin
      qprod       = 33'(prod2[r][31:16]) * 33'(RECIP_125_HI);
      qa3_next[r] = 10'(qprod >> 23);
      qmul        = 17'(qa3_next[r]) * 17'(DIV_125);
      ra3_next[r] = 7'(17'(prod2[r][31:16]) - qmul);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fs3  <= fs2;
      cen3 <= is_centred(thr2) && is_centred(str2) && is_centred(mov2);
      for (int i = 0; i < NUM_MOTORS; i++) tgt3[i] <= tgt3_next[i];
      for (int r = 0; r < NUM_RATES; r++) begin
        qa3[r] <= qa3_next[r];
        ra3[r] <= ra3_next[r];
        lo3[r] <= prod2[r][15:0];
      end
    end
  end

  // stage 4: second half of the divide, step = rate * elapsed * 256 / 1000
  logic              v4, fs4, cen4;
  cmd_t              tgt4 [NUM_MOTORS];
  logic [STEP_W-1:0] step4 [NUM_RATES];
  logic [STEP_W-1:0] step4_next [NUM_RATES];

  always_comb begin
    logic [27:0] z;
    logic [56:0] zprod;
    for (int r = 0; r < NUM_RATES; r++) begin
      z             = {ra3[r], lo3[r], 5'b0};
      zprod         = 57'(z) * 57'(RECIP_125_LO);
      step4_next[r] = {qa3[r], 21'b0} + STEP_W'(zprod >> 35);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fs4  <= fs3;
      cen4 <= cen3;
      for (int i = 0; i < NUM_MOTORS; i++) tgt4[i] <= tgt3[i];
      for (int r = 0; r < NUM_RATES; r++) step4[r] <= step4_next[r];
    end
  end

  // stage 5: ramp against held commands, result register
  cmd_t               cmd [NUM_MOTORS];
  cmd_t               cmd_next [NUM_MOTORS];
  logic signed [15:0] rpm_next [NUM_MOTORS];
  logic               armed_flag, armed_next;

  always_comb begin
    logic signed [32:0] cur, tgt, stp, hi, lo, c, cr;
    logic [32:0]        mag;
    logic               drive;
    drive      = !fs4 && armed_flag;
    armed_next = fs4 ? 1'b0 : (armed_flag || cen4);
    for (int i = 0; i < NUM_MOTORS; i++) begin
      cur = 33'(cmd[i]);
      tgt = drive ? 33'(tgt4[i]) : '0;
      stp = signed'(33'(step4[i >> 1]));
      hi  = cur + stp;
      lo  = cur - stp;
      if (tgt > hi) c = hi;
      else if (tgt < lo) c = lo;
      else c = tgt;
      mag = (c < 0) ? 33'(-c) : 33'(c);
      if (tgt == 0) begin
        if (i < 2 && mag < SNAP_TRACTION) c = '0;
        if (i >= 4 && mag < SNAP_REAR) c = '0;
      end
      cmd_next[i] = CMD_W'(c);
      cr          = (c < 0) ? c + 33'sd255 : c;
      rpm_next[i] = 16'(cr >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      armed_flag <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) cmd[i] <= '0;
    end else if (adv) begin
      out_valid <= v4;
      if (v4) begin
        armed_flag <= armed_next;
        for (int i = 0; i < NUM_MOTORS; i++) cmd[i] <= cmd_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4) begin
      left_rpm        <= rpm_next[0];
      right_rpm       <= rpm_next[1];
      front_left_rpm  <= rpm_next[2];
      front_right_rpm <= rpm_next[3];
      rear_left_rpm   <= rpm_next[4];
      rear_right_rpm  <= rpm_next[5];
      armed           <= armed_next;
      failsafe        <= fs4;
    end
  end

endmodule

`default_nettype wire
